/* rtl/swtb_pkg.sv */
// ----------------------------------------------------------------------------
// swtb_pkg
// Types, codes and axis helpers shared by the stamp tile binner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package swtb_pkg;

    localparam int MAP_BITS   = 9;                 // 512 texel map per axis
    localparam int TILE_SHIFT = 3;                 // 8x8 texel tiles
    localparam int TILE_BITS  = MAP_BITS - TILE_SHIFT;
    localparam int IDX_BITS   = 2 * TILE_BITS;     // tile index {ty, tx}
    localparam int MARK_WORD  = 32;
    localparam int MARK_BITS  = 5;
    localparam int MARK_ADDR  = IDX_BITS - MARK_BITS;
    localparam int MARK_DEPTH = 1 << MARK_ADDR;
    localparam int CAP_BITS   = 10;
    localparam int TILE_CAP   = 1 << CAP_BITS;
    localparam int LEN_BITS   = CAP_BITS + 1;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_STAMP = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVF     = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    localparam logic [1:0] CFG_WIN_X = 2'd0;
    localparam logic [1:0] CFG_WIN_Y = 2'd1;
    localparam logic [1:0] CFG_MAP_X = 2'd2;
    localparam logic [1:0] CFG_MAP_Y = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic [23:0]        radius;
        logic [9:0]         read_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] list_count;
        logic [5:0]  tile_x;
        logic [5:0]  tile_y;
        logic        entry_valid;
    } out_item_t;

    typedef struct packed {
        logic                outside;
        logic [MAP_BITS-1:0] l0;
        logic [MAP_BITS-1:0] l1;
    } clamp_t;

    typedef struct packed {
        logic [TILE_BITS-1:0] lo0;
        logic [TILE_BITS-1:0] hi0;
        logic [TILE_BITS-1:0] lo1;
        logic [TILE_BITS-1:0] hi1;
        logic                 two;
    } axis_tiles_t;

    typedef struct packed {
        logic [1:0]  op;
        logic        outside;
        logic [9:0]  read_index;
        axis_tiles_t x;
        axis_tiles_t y;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RD,
        B_CHK,
        B_LIST
    } back_state_t;

    // Window texel range of one axis, clamped to the window.
    function automatic clamp_t axis_clamp(input logic signed [32:0] lo,
                                          input logic signed [32:0] hi,
                                          input logic [23:0] win);
        logic signed [33:0] w;
        logic signed [33:0] d0;
        logic signed [33:0] d1;
        logic signed [25:0] l0;
        logic signed [25:0] l1;
        logic signed [25:0] l0c;
        logic signed [25:0] l1c;
        clamp_t             c;
        w   = {{2{win[23]}}, win, 8'd0};
        d0  = {lo[32], lo} - w;
        d1  = {hi[32], hi} - w;
        l0  = d0[33:8];
        l1  = d1[33:8];
        l0c = (l0 < 26'sd0) ? 26'sd0 : l0;
        l1c = (l1 > 26'sd511) ? 26'sd511 : l1;
        c.outside = (l0c > l1c);
        c.l0      = l0c[MAP_BITS-1:0];
        c.l1      = l1c[MAP_BITS-1:0];
        return c;
    endfunction

    // Split the clamped range at the wrap seam into tile runs.
    function automatic axis_tiles_t axis_split(input logic [MAP_BITS-1:0] l0,
                                               input logic [MAP_BITS-1:0] l1,
                                               input logic [MAP_BITS-1:0] morg);
        logic [MAP_BITS-1:0] p;
        logic [MAP_BITS:0]   len;
        logic [MAP_BITS:0]   rem;
        logic [MAP_BITS:0]   run;
        logic [MAP_BITS:0]   e0;
        logic [MAP_BITS:0]   e1;
        axis_tiles_t         t;
        p   = l0 + morg;
        len = {1'b0, l1} - {1'b0, l0} + 1'b1;
        rem = (MAP_BITS+1)'(1 << MAP_BITS) - {1'b0, p};
        run = (len < rem) ? len : rem;
        e0  = {1'b0, p} + run - 1'b1;
        e1  = len - run - 1'b1;
        t.lo0 = p[MAP_BITS-1:TILE_SHIFT];
        t.hi0 = e0[MAP_BITS-1:TILE_SHIFT];
        t.lo1 = '0;
        t.hi1 = e1[MAP_BITS-1:TILE_SHIFT];
        t.two = (run < len);
        return t;
    endfunction

endpackage

`default_nettype wire

/* rtl/wrapped_stamp_tile_binner.sv */
// ----------------------------------------------------------------------------
// wrapped_stamp_tile_binner
// Bins capsule stamps into 8x8 tiles of a 512x512 wrapped map.
// ----------------------------------------------------------------------------
// One command at a time: an item is taken when start is high and busy low,
// and exactly one result comes back on result with done high for a single
// cycle; the receiver cannot stall it, so capture it when done is seen.
// Clear and unused opcodes, and stamps that are outside the window or arrive
// after overflow, are answered straight from the back's idle state; a read
// passes through the list state, and a stamp walks its tiles through a read
// and a check state per tile, since every tile is a read-modify-write of the
// one-port tile mark memory. Write configuration only while busy is low. The
// front bounds and clamps the stamp in two stages, a two-entry queue carries
// the command, and the back walks tiles, marks them and appends new ones to
// the 1024-entry tile list.
`default_nettype none

module wrapped_stamp_tile_binner
    import swtb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire in_item_t    item,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    output logic             done,
    output out_item_t        result
);

    logic accept;
    logic q_push, q_ready, q_pop, q_valid;
    logic front_active, back_active;
    cmd_t push_cmd, head_cmd;

    // Hold off new items until the current one has fully drained.
    assign accept = start && !busy;
    assign busy   = front_active || q_valid || back_active;

    swtb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_cmd     (push_cmd),
        .active    (front_active)
    );

    swtb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    swtb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (head_cmd),
        .pop     (q_pop),
        .active  (back_active),
        .done    (done),
        .result  (result)
    );

endmodule

`default_nettype wire

/* rtl/swtb_front.sv */
// ----------------------------------------------------------------------------
// swtb_front
// Holds configuration, bounds each stamp and splits it into tile runs.
// ----------------------------------------------------------------------------
`default_nettype none

module swtb_front
    import swtb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire in_item_t item,
    input  wire logic     cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic     q_ready,
    output logic          q_push,
    output cmd_t          q_cmd,
    output logic          active
);

    logic [23:0]         win_x_reg, win_y_reg;
    logic [MAP_BITS-1:0] map_x_reg, map_y_reg;

    logic               s1_valid_reg;
    logic [1:0]         s1_op_reg;
    logic [9:0]         s1_idx_reg;
    logic signed [32:0] lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg;

    logic               s2_valid_reg;
    logic [1:0]         s2_op_reg;
    logic [9:0]         s2_idx_reg;
    clamp_t             cx_reg, cy_reg;

    logic signed [31:0] min_x, max_x, min_y, max_y;
    logic signed [32:0] rad;
    logic               s2_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_x_reg <= '0;
            win_y_reg <= '0;
            map_x_reg <= '0;
            map_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIN_X: win_x_reg <= cfg_data;
                CFG_WIN_Y: win_y_reg <= cfg_data;
                CFG_MAP_X: map_x_reg <= cfg_data[MAP_BITS-1:0];
                CFG_MAP_Y: map_y_reg <= cfg_data[MAP_BITS-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        min_x = (item.start_x < item.end_x) ? item.start_x : item.end_x;
        max_x = (item.start_x < item.end_x) ? item.end_x : item.start_x;
        min_y = (item.start_y < item.end_y) ? item.start_y : item.end_y;
        max_y = (item.start_y < item.end_y) ? item.end_y : item.start_y;
        rad   = {9'd0, item.radius};
    end

    assign s2_load = s1_valid_reg && (!s2_valid_reg || q_ready);
    assign q_push  = s2_valid_reg && q_ready;
    assign active  = s1_valid_reg || s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s2_load)
                s1_valid_reg <= 1'b0;
            if (s2_load)
                s2_valid_reg <= 1'b1;
            else if (q_push)
                s2_valid_reg <= 1'b0;
        end
    end

    // Payload: bound box on accept, clamp to window when stage 2 loads.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg  <= item.opcode;
            s1_idx_reg <= item.read_index;
            lo_x_reg   <= {min_x[31], min_x} - rad;
            hi_x_reg   <= {max_x[31], max_x} + rad;
            lo_y_reg   <= {min_y[31], min_y} - rad;
            hi_y_reg   <= {max_y[31], max_y} + rad;
        end
        if (s2_load)
        begin
            s2_op_reg  <= s1_op_reg;
            s2_idx_reg <= s1_idx_reg;
            cx_reg     <= axis_clamp(lo_x_reg, hi_x_reg, win_x_reg);
            cy_reg     <= axis_clamp(lo_y_reg, hi_y_reg, win_y_reg);
        end
    end

    always_comb
    begin
        q_cmd.op         = s2_op_reg;
        q_cmd.outside    = cx_reg.outside || cy_reg.outside;
        q_cmd.read_index = s2_idx_reg;
        q_cmd.x          = axis_split(cx_reg.l0, cx_reg.l1, map_x_reg);
        q_cmd.y          = axis_split(cy_reg.l0, cy_reg.l1, map_y_reg);
    end

endmodule

`default_nettype wire

/* rtl/swtb_queue.sv */
// ----------------------------------------------------------------------------
// swtb_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module swtb_queue
    import swtb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      ready,
    input  wire logic pop,
    output logic      valid,
    output cmd_t      head
);

    cmd_t       slot_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] count_reg;

    assign ready = (count_reg != 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = slot_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

/* rtl/swtb_back.sv */
// ----------------------------------------------------------------------------
// swtb_back
// Executes commands: clears the frame, walks stamp tiles, reads the list.
// ----------------------------------------------------------------------------
`default_nettype none

module swtb_back
    import swtb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  wire cmd_t q_cmd,
    output logic      pop,
    output logic      active,
    output logic      done,
    output out_item_t result
);

    back_state_t          state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic                 rx_reg, rx_next, ry_reg, ry_next;
    logic [TILE_BITS-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic [LEN_BITS-1:0]  len_reg, len_next;
    logic                 ovf_reg, ovf_next;
    logic [MARK_DEPTH-1:0] mvalid_reg;
    logic                 done_reg;
    out_item_t            result_reg;

    logic [MARK_WORD-1:0] mark_mem [MARK_DEPTH];
    logic [MARK_WORD-1:0] mark_rd_reg;
    logic [IDX_BITS-1:0]  list_mem [TILE_CAP];
    logic [IDX_BITS-1:0]  list_rd_reg;

    logic [IDX_BITS-1:0]  tidx;
    logic [MARK_ADDR-1:0] waddr;
    logic [MARK_WORD-1:0] word, set_bit;
    logic                 mark_we, valid_clr, emit, em_valid, last;
    logic [1:0]           em_code;
    logic [TILE_BITS-1:0] em_tx, em_ty;
    logic [TILE_BITS-1:0] tx_hi, ty_hi, ty_lo, adv_tx, adv_ty;
    logic                 adv_rx, adv_ry;

    assign tidx    = {ty_reg, tx_reg};
    assign waddr   = tidx[IDX_BITS-1:MARK_BITS];
    assign set_bit = MARK_WORD'(1) << tidx[MARK_BITS-1:0];
    assign word    = mvalid_reg[waddr] ? mark_rd_reg : '0;
    assign active  = (state_reg != B_IDLE);
    assign done    = done_reg;
    assign result  = result_reg;

    // Next tile in walk order: columns, rows, x runs, then y runs.
    always_comb
    begin
        tx_hi  = rx_reg ? cmd_reg.x.hi1 : cmd_reg.x.hi0;
        ty_hi  = ry_reg ? cmd_reg.y.hi1 : cmd_reg.y.hi0;
        ty_lo  = ry_reg ? cmd_reg.y.lo1 : cmd_reg.y.lo0;
        adv_tx = tx_reg;
        adv_ty = ty_reg;
        adv_rx = rx_reg;
        adv_ry = ry_reg;
        last   = 1'b0;
        if (tx_reg != tx_hi)
            adv_tx = tx_reg + 1'b1;
        else if (ty_reg != ty_hi)
        begin
            adv_ty = ty_reg + 1'b1;
            adv_tx = rx_reg ? cmd_reg.x.lo1 : cmd_reg.x.lo0;
        end
        else if (!rx_reg && cmd_reg.x.two)
        begin
            adv_rx = 1'b1;
            adv_tx = cmd_reg.x.lo1;
            adv_ty = ty_lo;
        end
        else if (!ry_reg && cmd_reg.y.two)
        begin
            adv_ry = 1'b1;
            adv_rx = 1'b0;
            adv_tx = cmd_reg.x.lo0;
            adv_ty = cmd_reg.y.lo1;
        end
        else
            last = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        tx_next    = tx_reg;
        ty_next    = ty_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        pop        = 1'b0;
        mark_we    = 1'b0;
        valid_clr  = 1'b0;
        emit       = 1'b0;
        em_code    = ST_OK;
        em_valid   = 1'b0;
        em_tx      = '0;
        em_ty      = '0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    pop      = 1'b1;
                    cmd_next = q_cmd;
                    case (q_cmd.op)
                        OP_CLEAR:
                        begin
                            valid_clr = 1'b1;
                            len_next  = '0;
                            ovf_next  = 1'b0;
                            emit      = 1'b1;
                        end
                        OP_STAMP:
                        begin
                            if (ovf_reg)
                                emit = 1'b1;
                            else if (q_cmd.outside)
                            begin
                                emit    = 1'b1;
                                em_code = ST_OUTSIDE;
                            end
                            else
                            begin
                                rx_next    = 1'b0;
                                ry_next    = 1'b0;
                                tx_next    = q_cmd.x.lo0;
                                ty_next    = q_cmd.y.lo0;
                                state_next = B_RD;
                            end
                        end
                        OP_READ:
                            state_next = B_LIST;
                        default:
                            emit = 1'b1;
                    endcase
                end
            end
            B_RD:
                state_next = B_CHK;
            B_CHK:
            begin
                if (((word & set_bit) == '0) && (len_reg == LEN_BITS'(TILE_CAP)))
                begin
                    ovf_next   = 1'b1;
                    emit       = 1'b1;
                    state_next = B_IDLE;
                end
                else
                begin
                    if ((word & set_bit) == '0)
                    begin
                        mark_we  = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                    rx_next = adv_rx;
                    ry_next = adv_ry;
                    tx_next = adv_tx;
                    ty_next = adv_ty;
                    if (last)
                    begin
                        emit       = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                        state_next = B_RD;
                end
            end
            B_LIST:
            begin
                emit       = 1'b1;
                state_next = B_IDLE;
                if ({1'b0, cmd_reg.read_index} < len_reg)
                begin
                    em_valid = 1'b1;
                    em_tx    = list_rd_reg[TILE_BITS-1:0];
                    em_ty    = list_rd_reg[IDX_BITS-1:TILE_BITS];
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            mvalid_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            done_reg  <= emit;
            if (valid_clr)
                mvalid_reg <= '0;
            else if (mark_we)
                mvalid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        tx_reg  <= tx_next;
        ty_reg  <= ty_next;
        if (emit)
        begin
            result_reg.status      <= ovf_next ? ST_OVF : em_code;
            result_reg.list_count  <= len_next;
            result_reg.tile_x      <= em_tx;
            result_reg.tile_y      <= em_ty;
            result_reg.entry_valid <= em_valid;
        end
    end

    // Mark bitmap: read one word, merge the tile bit, write back.
    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[waddr] <= word | set_bit;
        mark_rd_reg <= mark_mem[waddr];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
            list_mem[len_reg[CAP_BITS-1:0]] <= tidx;
        if (pop)
            list_rd_reg <= list_mem[q_cmd.read_index];
    end

endmodule

`default_nettype wire

/* rtl/swtb_checker.sv */
// ----------------------------------------------------------------------------
// swtb_checker
// Port-level checks of the tile binner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swtb_checker
    import swtb_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      done,
    input wire out_item_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transfer did not raise busy");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in a row");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !start |=> !done)
        else $error("result without a transfer in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_OK || result.status == ST_OVF ||
                  result.status == ST_OUTSIDE))
        else $error("bad status code");

    a_entry_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.entry_valid |-> result.list_count != 11'd0)
        else $error("valid entry from an empty list");

endmodule

bind wrapped_stamp_tile_binner swtb_checker u_swtb_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

/* tb/tile_binner_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_binner_checker
// Watches the command, configuration and result ports of the tile binner,
// predicts each result from its own copy of the marks, list and registers,
// and compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------

module tile_binner_checker
    import swtb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  in_item_t  item,
    input  logic      cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [23:0] cfg_data,
    input  logic      done,
    input  out_item_t result,
    output int        errors,
    output int        pending
);

    logic [23:0] win_x, win_y;
    logic [8:0]  morg_x, morg_y;
    logic [4095:0] marks;
    logic [11:0] tiles [0:1023];
    int          list_len;
    bit          ovf;
    out_item_t   expected_q[$];

    assign pending = expected_q.size();

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("checker: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Clamp one axis to the window and split it at the wrap seam.
    function automatic bit axis_span(input longint a, input longint b, input longint r,
                                     input logic [23:0] win, input logic [8:0] morg,
                                     output int lo0, output int hi0,
                                     output int hi1, output bit two);
        longint lo, hi, w, l0, l1, p, len, run;
        lo = ((a < b) ? a : b) - r;
        hi = ((a > b) ? a : b) + r;
        w  = longint'($signed(win)) * 256;
        l0 = (lo - w) >>> 8;
        l1 = (hi - w) >>> 8;
        if (l0 < 0) l0 = 0;
        if (l1 > 511) l1 = 511;
        if (l0 > l1)
            return 0;
        p   = (l0 + morg) & 511;
        len = l1 - l0 + 1;
        run = (len < 512 - p) ? len : 512 - p;
        lo0 = int'(p);
        hi0 = int'(p + run - 1);
        two = (run < len);
        hi1 = int'(len - run - 1);
        return 1;
    endfunction

    // Walk the stamp's tiles; returns the stamp status.
    function automatic logic [1:0] bin_stamp(input in_item_t it);
        int xl[2], xh[2], yl[2], yh[2];
        int nx, ny, tx, ty, idx;
        bit tw;
        if (ovf)
            return ST_OVF;
        if (!axis_span(it.start_x, it.end_x, it.radius, win_x, morg_x, xl[0], xh[0], xh[1], tw))
            return ST_OUTSIDE;
        nx = tw ? 2 : 1;
        xl[1] = 0;
        if (!axis_span(it.start_y, it.end_y, it.radius, win_y, morg_y, yl[0], yh[0], yh[1], tw))
            return ST_OUTSIDE;
        ny = tw ? 2 : 1;
        yl[1] = 0;
        for (int ry = 0; ry < ny; ry++)
            for (int rx = 0; rx < nx; rx++)
                for (ty = yl[ry] >> 3; ty <= yh[ry] >> 3; ty++)
                    for (tx = xl[rx] >> 3; tx <= xh[rx] >> 3; tx++)
                    begin
                        idx = ty * 64 + tx;
                        if (marks[idx])
                            continue;
                        if (list_len >= TILE_CAP)
                        begin
                            ovf = 1;
                            return ST_OVF;
                        end
                        marks[idx] = 1'b1;
                        tiles[list_len] = {ty[5:0], tx[5:0]};
                        list_len++;
                    end
        return ST_OK;
    endfunction

    function automatic out_item_t predict(input in_item_t it);
        out_item_t r;
        r = '0;
        case (it.opcode)
            OP_CLEAR:
            begin
                marks = '0;
                list_len = 0;
                ovf = 0;
            end
            OP_STAMP: r.status = bin_stamp(it);
            OP_READ:
                if (int'(it.read_index) < list_len)
                begin
                    r.tile_x = tiles[it.read_index][5:0];
                    r.tile_y = tiles[it.read_index][11:6];
                    r.entry_valid = 1'b1;
                end
            default: ;
        endcase
        if (ovf)
            r.status = ST_OVF;
        r.list_count = list_len[10:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            win_x = '0; win_y = '0; morg_x = '0; morg_y = '0;
            marks = '0;
            list_len = 0;
            ovf = 0;
            expected_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                    report("result with nothing expected, status", result.status, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (result.status !== want.status)
                        report("status", result.status, want.status);
                    if (result.list_count !== want.list_count)
                        report("list_count", result.list_count, want.list_count);
                    if (result.tile_x !== want.tile_x)
                        report("tile_x", result.tile_x, want.tile_x);
                    if (result.tile_y !== want.tile_y)
                        report("tile_y", result.tile_y, want.tile_y);
                    if (result.entry_valid !== want.entry_valid)
                        report("entry_valid", result.entry_valid, want.entry_valid);
                end
            end
            if (cfg_we)
                case (cfg_index)
                    CFG_WIN_X: win_x = cfg_data;
                    CFG_WIN_Y: win_y = cfg_data;
                    CFG_MAP_X: morg_x = cfg_data[8:0];
                    CFG_MAP_Y: morg_y = cfg_data[8:0];
                    default: ;
                endcase
            if (start && !busy)
                expected_q = {expected_q, predict(item)};
        end
    end

    initial
    begin
        errors = 0;
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the wrapped stamp tile binner.
// ----------------------------------------------------------------------------
// A directed opening covers clear, read, unused opcode, seam-crossing and
// outside stamps, list overflow and stamps while overflowed. Random phases
// follow, each under its own window and map origin, with stamps aimed near
// the window, occasional wild coordinates and frequent frame clears. The
// checker beside the block predicts and compares every result.

module tb;
    import swtb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    item;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        done;
    out_item_t   result;
    int          errors;
    int          pending;
    int          idle_cycles;

    // current window origins, used to aim stamps
    logic [23:0] aim_x, aim_y;

    wrapped_stamp_tile_binner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    tile_binner_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Watchdog: end the run after a long stretch with no transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 60000)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Write all four registers back to back; only call while idle.
    task automatic set_regs(input logic [23:0] wx, input logic [23:0] wy,
                            input logic [8:0] mx, input logic [8:0] my);
        logic [23:0] vals[4];
        vals = '{wx, wy, {15'd0, mx}, {15'd0, my}};
        aim_x = wx;
        aim_y = wy;
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Hold the sender until every result is back, plus a short margin.
    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Send one command; start stays high between back-to-back transfers.
    task automatic send(input in_item_t it);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic in_item_t make(input logic [1:0] op, input int sx, input int sy,
                                      input int ex, input int ey, input logic [23:0] r,
                                      input logic [9:0] ri);
        in_item_t it;
        it.opcode = op;
        it.start_x = sx;
        it.start_y = sy;
        it.end_x = ex;
        it.end_y = ey;
        it.radius = r;
        it.read_index = ri;
        return it;
    endfunction

    // World coordinate near the window, with a random fraction.
    function automatic int near(input logic [23:0] win);
        int texel;
        texel = int'($signed(win)) + $urandom_range(0, 640) - 64;
        return texel * 256 + $urandom_range(0, 255);
    endfunction

    function automatic in_item_t random_cmd();
        int pick;
        int sx, sy;
        logic [23:0] r;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return make(OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                        24'($urandom), 10'($urandom));
        if (pick < 7)
            return make(OP_SPARE, $urandom, $urandom, $urandom, $urandom,
                        24'($urandom), 10'($urandom));
        if (pick < 37)
            return make(OP_READ, $urandom, $urandom, $urandom, $urandom, 24'($urandom),
                        ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 63)) : 10'($urandom));
        if (pick < 42)
            return make(OP_STAMP, $urandom, $urandom, $urandom, $urandom,
                        24'($urandom), 10'($urandom));
        sx = near(aim_x);
        sy = near(aim_y);
        if ($urandom_range(0, 19) == 0)
            r = 24'($urandom_range(0, 300 * 256));
        else
            r = 24'($urandom_range(0, 12 * 256));
        return make(OP_STAMP, sx, sy, sx + $urandom_range(0, 24 * 256) - 12 * 256,
                    sy + $urandom_range(0, 24 * 256) - 12 * 256, r, 10'($urandom));
    endfunction

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_WIN_X;
        cfg_data = '0;
        aim_x = '0;
        aim_y = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening with the map origin near the seam.
        set_regs(24'd0, 24'd0, 9'd500, 9'd505);
        send(make(OP_READ, 0, 0, 0, 0, 0, 10'd0));
        send(make(OP_STAMP, 0, 0, 0, 0, 0, 10'd0));
        send(make(OP_STAMP, 5 * 256, 3 * 256, 20 * 256 + 255, 9 * 256, 24'd512, 10'd0));
        send(make(OP_STAMP, 5 * 256, 3 * 256, 20 * 256, 9 * 256, 24'd512, 10'd0));
        send(make(OP_READ, 0, 0, 0, 0, 0, 10'd1));
        send(make(OP_READ, 0, 0, 0, 0, 0, 10'd1023));
        send(make(OP_STAMP, -100 * 256, 10, -50 * 256, 20, 24'd0, 10'd0));
        send(make(OP_STAMP, 10, 600 * 256, 20, 700 * 256, 24'd0, 10'd0));
        send(make(OP_STAMP, -1, -1, -1, -1, 24'd1, 10'd0));
        send(make(OP_SPARE, -1, -1, -1, -1, 24'hFFFFFF, 10'h3FF));
        send(make(OP_STAMP, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                  24'hFFFFFF, 10'h3FF));
        send(make(OP_READ, 0, 0, 0, 0, 0, 10'd1023));
        send(make(OP_STAMP, 0, 0, 0, 0, 24'd8, 10'd0));
        send(make(OP_READ, 0, 0, 0, 0, 0, 10'd0));
        send(make(OP_CLEAR, 0, 0, 0, 0, 0, 10'd0));
        send(make(OP_STAMP, 256 * 256, 256 * 256, 256 * 256, 256 * 256, 24'(300 * 256),
                  10'd0));
        send(make(OP_READ, 0, 0, 0, 0, 0, 10'd1023));
        send(make(OP_CLEAR, 0, 0, 0, 0, 0, 10'd0));
        send(make(OP_STAMP, 511 * 256, 511 * 256, 511 * 256 + 255, 511 * 256 + 255,
                  24'd0, 10'd0));
        send(make(OP_READ, 0, 0, 0, 0, 0, 10'd0));
        start <= 1'b0;
        drain();

        // Random phases under different registers, extremes included.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_regs(24'd0, 24'd0, 9'd0, 9'd0);
                1: set_regs(24'h800000, 24'h7FFF00, 9'd511, 9'd511);
                2: set_regs(24'($urandom), 24'($urandom), 9'($urandom), 9'($urandom));
                3: set_regs(24'hFFFF80, 24'd1000, 9'd260, 9'd7);
                4: set_regs(24'h7FFFFF, 24'h800000, 9'd0, 9'd511);
                default: set_regs(24'($urandom_range(0, 4000)), 24'hFFFFF0,
                                  9'($urandom), 9'($urandom));
            endcase
            send(make(OP_CLEAR, 0, 0, 0, 0, 0, 10'd0));
            for (int n = 0; n < 250; n++)
                send(random_cmd());
            start <= 1'b0;
            drain();
        end

        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
